>>> hdl/htb_pkg.sv
package htb_pkg;
  localparam int ATAN_COUNT = 28;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_FRAC = 30;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0: r = 34'sd536870912;
      5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;
      5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;
      5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10680862;
      5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;
      5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41721;
      5'd15: r = 34'sd20860;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2607;
      5'd19: r = 34'sd1303;
      5'd20: r = 34'sd651;
      5'd21: r = 34'sd325;
      5'd22: r = 34'sd162;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd40;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  // one CORDIC lane word: x, y, residual angle, quadrant
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
  } cordic_lane_t;

  typedef struct packed {
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    cordic_lane_t       lx;
    cordic_lane_t       ly;
    cordic_lane_t       lz;
  } htb_word_t;
endpackage

>>> hdl/htb_if.sv
interface htb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic signed [31:0] shift_z;
  logic [15:0]        angle_x;
  logic [15:0]        angle_y;
  logic [15:0]        angle_z;
  modport source (output valid, shift_x, shift_y, shift_z, angle_x, angle_y, angle_z,
                  input ready);
  modport sink (input valid, shift_x, shift_y, shift_z, angle_x, angle_y, angle_z,
                output ready);
endinterface

interface htb_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic signed [31:0] entry_col0;
  logic signed [31:0] entry_col1;
  logic signed [31:0] entry_col2;
  logic signed [31:0] entry_col3;
  logic               row_last;
  modport source (output valid, row_index, entry_col0, entry_col1, entry_col2, entry_col3,
                  row_last, input ready);
  modport sink (input valid, row_index, entry_col0, entry_col1, entry_col2, entry_col3,
                row_last, output ready);
endinterface

>>> hdl/htb_cell.sv
// One CORDIC micro-rotation for all three angles; a pipeline cell.
module htb_cell #(
  parameter int STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  htb_pkg::htb_word_t  word_i,
  output logic                valid_o,
  output htb_pkg::htb_word_t  word_o
);
  import htb_pkg::*;

  localparam logic [4:0] STEP_IDX = 5'(STEP);

  function automatic cordic_lane_t rot(input cordic_lane_t l);
    cordic_lane_t r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    dx = l.y >>> STEP;
    dy = l.x >>> STEP;
    at = atan_turn(STEP_IDX);
    r = l;
    if (!l.z[33]) begin
      r.x = l.x - dx;
      r.y = l.y + dy;
      r.z = l.z - at;
    end else begin
      r.x = l.x + dx;
      r.y = l.y - dy;
      r.z = l.z + at;
    end
    return r;
  endfunction

  htb_word_t word_d, word_q;
  logic      valid_q;

  always_comb begin
    word_d = word_i;
    word_d.lx = rot(word_i.lx);
    word_d.ly = rot(word_i.ly);
    word_d.lz = rot(word_i.lz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
endmodule

>>> hdl/htb_matrix.sv
// Matrix assembly: one pipelined product stage per cycle unless held by the output, then rows out.
module htb_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  htb_pkg::htb_word_t word_i,
  output logic               ready_o,
  htb_out_if.source          out_o
);
  import htb_pkg::*;

  localparam int SH = CORDIC_FRAC - FRAC_BITS;

  function automatic logic signed [33:0] trig_round(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v + (34'sd1 <<< (SH - 1));
    return t >>> SH;
  endfunction

  // product of two trig values (|v| <= ~1.0) rounded to FRAC_BITS
  function automatic logic signed [33:0] fmul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] pr;
    pr = 68'(a) * 68'(b) + (68'sd1 <<< (FRAC_BITS - 1));
    pr = pr >>> FRAC_BITS;
    return pr[33:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void quad_fix(input cordic_lane_t l,
                                   output logic signed [33:0] c,
                                   output logic signed [33:0] s);
    logic signed [33:0] cc;
    logic signed [33:0] ss;
    cc = trig_round(l.x);
    ss = trig_round(l.y);
    unique case (l.quad)
      2'd0: begin c = cc;  s = ss;  end
      2'd1: begin c = -ss; s = cc;  end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  // stage A: sine/cosine
  logic a_v_q;
  logic signed [33:0] cx_q, sx_q, cy_q, sy_q, cz_q, sz_q;
  logic signed [31:0] tx_q, ty_q, tz_q;
  // stage B: first products
  logic b_v_q;
  logic signed [33:0] p_q, qq_q, b_cx_q, b_sx_q, b_cy_q, b_sy_q, b_cz_q, b_sz_q;
  logic signed [31:0] bx_q, by_q, bz_q;
  // stage C: entries
  logic c_v_q;
  logic signed [31:0] m_q [0:2][0:3];
  // row emitter
  logic [1:0] row_q;
  logic       busy_q;
  logic signed [31:0] r_q [0:2][0:3];
  logic       fire;
  logic       adv;

  assign fire = out_o.valid && out_o.ready;
  // the output holds one matrix; the pipeline moves when it can drain into it
  assign adv = !c_v_q || !busy_q || (fire && row_q == 2'd3);
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      busy_q <= 1'b0;
      row_q <= 2'd0;
    end else begin
      if (adv) begin
        a_v_q <= valid_i;
        b_v_q <= a_v_q;
        c_v_q <= b_v_q;
      end
      // load a new matrix, else advance the row on each accepted word
      if (adv && c_v_q) begin
        busy_q <= 1'b1;
        row_q <= 2'd0;
      end else if (fire) begin
        row_q <= row_q + 2'd1;
        if (row_q == 2'd3) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [33:0] c0, s0, c1, s1, c2, s2;
    if (adv) begin
      quad_fix(word_i.lx, c0, s0);
      quad_fix(word_i.ly, c1, s1);
      quad_fix(word_i.lz, c2, s2);
      cx_q <= c0; sx_q <= s0; cy_q <= c1; sy_q <= s1; cz_q <= c2; sz_q <= s2;
      tx_q <= word_i.shift_x; ty_q <= word_i.shift_y; tz_q <= word_i.shift_z;

      p_q  <= fmul(sx_q, sy_q);
      qq_q <= fmul(cx_q, sy_q);
      b_cx_q <= cx_q; b_sx_q <= sx_q; b_cy_q <= cy_q;
      b_sy_q <= sy_q; b_cz_q <= cz_q; b_sz_q <= sz_q;
      bx_q <= tx_q; by_q <= ty_q; bz_q <= tz_q;

      m_q[0][0] <= sat32(36'(fmul(b_cy_q, b_cz_q)));
      m_q[0][1] <= sat32(-36'(fmul(b_cy_q, b_sz_q)));
      m_q[0][2] <= sat32(36'(b_sy_q));
      m_q[0][3] <= bx_q;
      m_q[1][0] <= sat32(36'(fmul(p_q, b_cz_q)) + 36'(fmul(b_cx_q, b_sz_q)));
      m_q[1][1] <= sat32(36'(fmul(b_cx_q, b_cz_q)) - 36'(fmul(p_q, b_sz_q)));
      m_q[1][2] <= sat32(-36'(fmul(b_sx_q, b_cy_q)));
      m_q[1][3] <= by_q;
      m_q[2][0] <= sat32(36'(fmul(b_sx_q, b_sz_q)) - 36'(fmul(qq_q, b_cz_q)));
      m_q[2][1] <= sat32(36'(fmul(qq_q, b_sz_q)) + 36'(fmul(b_sx_q, b_cz_q)));
      m_q[2][2] <= sat32(36'(fmul(b_cx_q, b_cy_q)));
      m_q[2][3] <= bz_q;
      if (c_v_q) r_q <= m_q;
    end
  end

  always_comb begin
    out_o.valid = busy_q;
    out_o.row_index = row_q;
    out_o.row_last = (row_q == 2'd3);
    if (row_q == 2'd3) begin
      out_o.entry_col0 = '0;
      out_o.entry_col1 = '0;
      out_o.entry_col2 = '0;
      out_o.entry_col3 = 32'(1) << FRAC_BITS;
    end else begin
      out_o.entry_col0 = r_q[row_q][0];
      out_o.entry_col1 = r_q[row_q][1];
      out_o.entry_col2 = r_q[row_q][2];
      out_o.entry_col3 = r_q[row_q][3];
    end
  end
endmodule

>>> hdl/homogeneous_transform_builder_core.sv
// Homogeneous transform builder, XYZ Euler order (M = T * Rx * Ry * Rz).
// Input channel in_i: one word per transform (three Q shifts, three binary
// angles). Output channel out_o: four words per transform, rows 0..3 in
// order, row_last marking row 3.
// A chain of N CORDIC cells (N = TRIG_ITERATIONS clamped to 28) computes all
// three sine/cosine pairs in lockstep, then three stages (quadrant fix, first
// products, entries) build the matrix and a row register sends it out.
// The output rate is set by the single output channel, which moves one row per
// cycle while the receiver is ready; the chain accepts a new word each cycle
// while the output matrix register has room.
// Reset clears all valid flags; no words are in flight afterwards.
// When the receiver stalls the current row holds; the chain keeps moving
// until a second matrix waits in the last stage, then it freezes and
// in_i.ready drops until the held matrix drains.
module homogeneous_transform_builder_core #(
  parameter int FRAC_BITS = 16,
  parameter int TRIG_ITERATIONS = 18
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  htb_in_if.sink    in_i,
  htb_out_if.source out_o
);
  import htb_pkg::*;

  localparam int N = (TRIG_ITERATIONS > ATAN_COUNT) ? ATAN_COUNT : TRIG_ITERATIONS;

  htb_word_t w [0:N];
  logic      v [0:N];
  logic      adv;

  function automatic cordic_lane_t lane_init(input logic [15:0] ang);
    cordic_lane_t l;
    logic [31:0] a;
    logic [31:0] qd;
    a = {ang, 16'h0};
    qd = (a + 32'h2000_0000) >> 30;
    l.quad = qd[1:0];
    a = a - {qd[1:0], 30'h0};
    l.z = 34'(signed'(a));
    l.x = CORDIC_GAIN;
    l.y = '0;
    return l;
  endfunction

  always_comb begin
    w[0].shift_x = in_i.shift_x;
    w[0].shift_y = in_i.shift_y;
    w[0].shift_z = in_i.shift_z;
    w[0].lx = lane_init(in_i.angle_x);
    w[0].ly = lane_init(in_i.angle_y);
    w[0].lz = lane_init(in_i.angle_z);
    v[0] = in_i.valid;
  end

  assign in_i.ready = adv;

  for (genvar g = 0; g < N; g++) begin : g_cell
    htb_cell #(.STEP(g)) u_cell (
      .clk_i, .rst_ni, .en_i(adv),
      .valid_i(v[g]), .word_i(w[g]),
      .valid_o(v[g+1]), .word_o(w[g+1])
    );
  end

  htb_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk_i, .rst_ni, .valid_i(v[N]), .word_i(w[N]), .ready_o(adv), .out_o(out_o)
  );
endmodule

>>> verif/tb_homogeneous_transform_builder_core.sv
`timescale 1ns / 100ps

module tb_homogeneous_transform_builder_core;
  import htb_pkg::*;

  localparam int FRAC_BITS       = 16;
  localparam int TRIG_ITERATIONS = 18;
  localparam int TRIG_STEPS      = (TRIG_ITERATIONS > 28) ? 28 : TRIG_ITERATIONS;
  localparam int LATENCY         = TRIG_ITERATIONS + 5;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] entry_col0;
    logic signed [31:0] entry_col1;
    logic signed [31:0] entry_col2;
    logic signed [31:0] entry_col3;
    logic               row_last;
  } matrix_row_t;

  const longint atan_step[28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20, 10, 5
  };

  logic clk_i;
  logic rst_ni;
  int   error_count;
  int   cycle_count;
  bit   idle_en;
  int   out_stall;

  matrix_row_t pending_rows[$];

  htb_in_if  in_if ();
  htb_out_if out_if ();

  homogeneous_transform_builder_core #(
    .FRAC_BITS      (FRAC_BITS),
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint fix_mul(longint a, longint b);
    return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic angle_sincos(input logic [15:0] ang, output longint cos_v,
                              output longint sin_v);
    logic [31:0] turn;
    logic [31:0] resid;
    logic [1:0]  quad;
    longint      x, y, z, dx, dy, c, s, half;
    turn  = {ang, 16'h0000};
    quad  = 2'((turn + 32'h20000000) >> 30);
    resid = turn - ({30'd0, quad} << 30);
    z     = longint'($signed(resid));
    x     = 652032874;
    y     = 0;
    for (int i = 0; i < TRIG_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_step[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_step[i];
      end
    end
    half = longint'(1) <<< (30 - FRAC_BITS - 1);
    c = (x + half) >>> (30 - FRAC_BITS);
    s = (y + half) >>> (30 - FRAC_BITS);
    case (quad)
      2'd0: begin cos_v = c;  sin_v = s;  end
      2'd1: begin cos_v = -s; sin_v = c;  end
      2'd2: begin cos_v = -c; sin_v = -s; end
      default: begin cos_v = s; sin_v = -c; end
    endcase
  endtask

  task automatic predict_matrix(input logic signed [31:0] tx, ty, tz,
                                input logic [15:0] ax, ay, az);
    longint cx, sx, cy, sy, cz, sz, p, q;
    matrix_row_t r;
    angle_sincos(ax, cx, sx);
    angle_sincos(ay, cy, sy);
    angle_sincos(az, cz, sz);
    p = fix_mul(sx, sy);
    q = fix_mul(cx, sy);
    r = '{2'd0, clamp32(fix_mul(cy, cz)), clamp32(-fix_mul(cy, sz)), clamp32(sy), tx, 1'b0};
    pending_rows.push_back(r);
    r = '{2'd1, clamp32(fix_mul(p, cz) + fix_mul(cx, sz)),
          clamp32(fix_mul(cx, cz) - fix_mul(p, sz)), clamp32(-fix_mul(sx, cy)), ty, 1'b0};
    pending_rows.push_back(r);
    r = '{2'd2, clamp32(fix_mul(sx, sz) - fix_mul(q, cz)),
          clamp32(fix_mul(q, sz) + fix_mul(sx, cz)), clamp32(fix_mul(cx, cy)), tz, 1'b0};
    pending_rows.push_back(r);
    r = '{2'd3, 32'sd0, 32'sd0, 32'sd0, 32'sd1 <<< FRAC_BITS, 1'b1};
    pending_rows.push_back(r);
  endtask

  // leave valid high when the next word follows directly
  task automatic send_transform(input logic signed [31:0] tx, ty, tz,
                                input logic [15:0] ax, ay, az);
    int gap;
    in_if.valid   <= 1'b1;
    in_if.shift_x <= tx;
    in_if.shift_y <= ty;
    in_if.shift_z <= tz;
    in_if.angle_x <= ax;
    in_if.angle_y <= ay;
    in_if.angle_z <= az;
    do @(posedge clk_i); while (!in_if.ready);
    predict_matrix(tx, ty, tz, ax, ay, az);
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random;
    send_transform($signed($urandom), $signed($urandom), $signed($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_corner_angles;
    logic [15:0] corners[8] = '{16'h0000, 16'h2000, 16'h4000, 16'h8000,
                                16'hc000, 16'hdfff, 16'hffff, 16'h0001};
    // axis-aligned quadrants and the eighth-turn boundaries on every axis
    for (int i = 0; i < 8; i++)
      send_transform(32'sh7fffffff, 32'sh80000000, 32'sd0, corners[i], corners[7 - i],
                     corners[(i + 3) % 8]);
    send_transform(32'sh80000000, 32'sh7fffffff, 32'shffffffff, 16'hffff, 16'hffff, 16'hffff);
    send_transform(32'sd0, 32'sd0, 32'sh7fffffff, 16'h0000, 16'h0000, 16'h0000);
    send_transform(32'sh00010000, 32'shffff0000, 32'sh80000000,
                   16'h1fff, 16'h6000, 16'ha000);
    send_transform(32'sh55555555, 32'shaaaaaaaa, 32'sh12345678,
                   16'h5555, 16'haaaa, 16'he000);
  endtask

  task automatic test_random_stalls;
    repeat (260) send_random();
  endtask

  task automatic test_back_to_back;
    idle_en = 1'b0;
    repeat (60) send_random();
    in_if.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    matrix_row_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected row %0d", out_if.row_index);
        error_count++;
      end else begin
        want = pending_rows.pop_front();
        if (out_if.row_index !== want.row_index) begin
          $error("row_index: expected %0d actual %0d", want.row_index, out_if.row_index);
          error_count++;
        end
        if (out_if.entry_col0 !== want.entry_col0) begin
          $error("entry_col0: expected %0d actual %0d", want.entry_col0, out_if.entry_col0);
          error_count++;
        end
        if (out_if.entry_col1 !== want.entry_col1) begin
          $error("entry_col1: expected %0d actual %0d", want.entry_col1, out_if.entry_col1);
          error_count++;
        end
        if (out_if.entry_col2 !== want.entry_col2) begin
          $error("entry_col2: expected %0d actual %0d", want.entry_col2, out_if.entry_col2);
          error_count++;
        end
        if (out_if.entry_col3 !== want.entry_col3) begin
          $error("entry_col3: expected %0d actual %0d", want.entry_col3, out_if.entry_col3);
          error_count++;
        end
        if (out_if.row_last !== want.row_last) begin
          $error("row_last: expected %0d actual %0d", want.row_last, out_if.row_last);
          error_count++;
        end
      end
    end
    // receiver stalls in bursts
    if (out_stall > 0) begin
      out_stall    <= out_stall - 1;
      out_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall    <= $urandom_range(0, 17);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[homogeneous_transform_builder_core] ERROR");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    out_stall     = 0;
    idle_en       = 1'b1;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.shift_x = '0;
    in_if.shift_y = '0;
    in_if.shift_z = '0;
    in_if.angle_x = '0;
    in_if.angle_y = '0;
    in_if.angle_z = '0;
    out_if.ready  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_angles();
    test_random_stalls();
    test_back_to_back();
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0)
      $display("[homogeneous_transform_builder_core] OK");
    else
      $display("[homogeneous_transform_builder_core] ERROR");
    $finish;
  end
endmodule
